// ----- sv/wu_antialiased_line_drawer_assert.svh -----
// Assertion macros for the line drawer checker.
`ifndef WU_ANTIALIASED_LINE_DRAWER_ASSERT_SVH
`define WU_ANTIALIASED_LINE_DRAWER_ASSERT_SVH
// Assert an implication on every clock edge outside reset.
`define WU_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// Assert an implication in the next cycle.
`define WU_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`endif

// ----- sv/wal_pkg.sv -----
// ---------------------------------------------------------------------------
// wal_pkg
// Shared types and constants of the antialiased line drawer.
// ---------------------------------------------------------------------------
`default_nettype none
package wal_pkg;
  localparam int WIDTH_DEF  = 256;
  localparam int HEIGHT_DEF = 256;
  localparam logic [1:0] CMD_DRAW  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;
  localparam logic [7:0] WHITE = 8'd255;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] x_start;
    logic [7:0] y_start;
    logic [7:0] x_end;
    logic [7:0] y_end;
    logic [7:0] gray;
  } cmd_t;
endpackage
`default_nettype wire

// ----- sv/wal_ram.sv -----
// ---------------------------------------------------------------------------
// wal_ram
// Single-port RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module wal_ram #(
  parameter int DW = 8,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [DW-1:0]            wdata,
  output logic      [DW-1:0]            rdata
);
  logic [DW-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- sv/wal_front.sv -----
// ---------------------------------------------------------------------------
// wal_front
// Input stage and two-entry command queue.
// ---------------------------------------------------------------------------
`default_nettype none
module wal_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire wal_pkg::cmd_t in_cmd,
  output logic               q_valid,
  input  wire logic          q_take,
  output wal_pkg::cmd_t      q_cmd
);
  wal_pkg::cmd_t slot [2];
  logic [1:0] count;
  logic       rp;
  logic       wp;
  logic       push;
  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = slot[rp];
  always_ff @(posedge clk) begin
    if (push) slot[wp] <= in_cmd;
    if (rst) begin
      count <= '0;
      rp <= 1'b0;
      wp <= 1'b0;
    end else begin
      if (push) wp <= !wp;
      if (q_take) rp <= !rp;
      count <= count + {1'b0, push} - {1'b0, q_take};
    end
  end
endmodule
`default_nettype wire

// ----- sv/wal_div.sv -----
// ---------------------------------------------------------------------------
// wal_div
// Restoring divider: (num << 16) / den, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module wal_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [7:0]  num,
  input  wire logic [7:0]  den,
  output logic             busy,
  output logic [15:0]      quo
);
  logic [7:0]  rem;
  logic [7:0]  dv;
  logic [23:0] dvd;
  logic [4:0]  cnt;
  logic [8:0]  rsh;
  logic [8:0]  diff;
  logic        take_bit;
  always_comb begin
    rsh = {rem, dvd[23]};
    diff = rsh - {1'b0, dv};
    take_bit = (rsh >= {1'b0, dv});
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 5'd24;
      rem <= '0;
      dvd <= {num, 16'd0};
      dv <= den;
      quo <= '0;
    end else if (busy) begin
      rem <= take_bit ? diff[7:0] : rsh[7:0];
      dvd <= {dvd[22:0], 1'b0};
      quo <= {quo[14:0], take_bit};
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ----- sv/wal_back.sv -----
// ---------------------------------------------------------------------------
// wal_back
// Command engine: clear sweep, reads, line stepping with read-modify-write.
// ---------------------------------------------------------------------------
`default_nettype none
module wal_back #(
  parameter int WIDTH  = wal_pkg::WIDTH_DEF,
  parameter int HEIGHT = wal_pkg::HEIGHT_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  output logic               q_take,
  input  wire wal_pkg::cmd_t q_cmd,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         pixel_value,
  output logic [1:0]         done_command
);
  localparam int XW = $clog2(WIDTH);
  localparam int YW = $clog2(HEIGHT);
  localparam int XA = (XW < 8) ? XW : 8;
  localparam int YA = (YW < 8) ? YW : 8;
  localparam int AW = XA + YA;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_CLR   = 12'b000000000010,
    S_RD    = 12'b000000000100,
    S_RDW   = 12'b000000001000,
    S_DIV   = 12'b000000010000,
    S_RUN   = 12'b000000100000,
    S_STEP  = 12'b000001000000,
    S_ARD   = 12'b000010000000,
    S_AWR   = 12'b000100000000,
    S_BRD   = 12'b001000000000,
    S_BWR   = 12'b010000000000,
    S_END   = 12'b100000000000
  } state_t;
  state_t st;

  logic we;
  logic [AW-1:0] addr;
  logic [7:0] wdata;
  logic [7:0] rdata;
  wal_ram #(.DW(8), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  logic div_start, div_busy;
  logic [15:0] quo;
  logic [7:0] dnum, dden;
  wal_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(dnum), .den(dden),
    .busy(div_busy), .quo(quo)
  );

  logic [8:0] cx, cy;
  logic [8:0] ex, ey;
  logic [7:0] dx, dy, steps, lg, major;
  logic xneg, ymaj, solid, quiet;
  logic [15:0] acc;
  logic [AW-1:0] clr;
  logic [1:0] cmdr;
  logic [8:0] px, py, xnext;
  logic inb;
  logic [7:0] wsel;
  logic signed [8:0] diff;
  logic signed [17:0] prod;
  logic signed [17:0] sum;
  logic [7:0] blend;
  logic [15:0] accn;

  always_comb begin
    xnext = xneg ? cx - 9'd1 : cx + 9'd1;
    px = cx;
    py = cy;
    wsel = acc[15:8];
    case (st)
      S_BRD, S_BWR: begin
        wsel = ~acc[15:8];
        if (ymaj) px = xnext;
        else py = cy + 9'd1;
      end
      S_END: begin
        px = ex;
        py = ey;
      end
      default: ;
    endcase
    inb = ({23'd0, px} < 32'(WIDTH)) && ({23'd0, py} < 32'(HEIGHT));
    addr = (st == S_CLR) ? clr : {py[YA-1:0], px[XA-1:0]};
    diff = $signed({1'b0, rdata}) - $signed({1'b0, lg});
    prod = $signed({1'b0, wsel}) * diff;
    sum = prod + $signed({2'b00, lg, 8'd0});
    blend = sum[17] ? 8'd0 : sum[15:8];
    we = 1'b0;
    wdata = lg;
    case (st)
      S_CLR: we = 1'b1;
      S_RUN, S_END: we = inb;
      S_STEP: we = solid && inb;
      S_AWR, S_BWR: begin
        we = inb;
        wdata = blend;
      end
      default: we = 1'b0;
    endcase
    accn = acc + quo;
    major = ymaj ? dy : dx;
    dnum = ymaj ? dx : dy;
    dden = major;
  end

  assign q_take = (st == S_IDLE) && q_valid && !out_valid;
  assign div_start = (st == S_RUN) && !solid;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_CLR;
      clr <= '0;
      lg <= wal_pkg::WHITE;
      quiet <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (st)
        S_IDLE: if (q_take) begin
          cmdr <= q_cmd.command;
          lg <= q_cmd.gray;
          pixel_value <= '0;
          quiet <= 1'b0;
          case (q_cmd.command)
            wal_pkg::CMD_CLEAR: begin clr <= '0; st <= S_CLR; end
            wal_pkg::CMD_READ: begin
              cx <= {1'b0, q_cmd.x_start};
              cy <= {1'b0, q_cmd.y_start};
              st <= S_RD;
            end
            wal_pkg::CMD_DRAW: begin
              if (q_cmd.y_start > q_cmd.y_end) begin
                cx <= {1'b0, q_cmd.x_end}; cy <= {1'b0, q_cmd.y_end};
                ex <= {1'b0, q_cmd.x_start}; ey <= {1'b0, q_cmd.y_start};
              end else begin
                cx <= {1'b0, q_cmd.x_start}; cy <= {1'b0, q_cmd.y_start};
                ex <= {1'b0, q_cmd.x_end}; ey <= {1'b0, q_cmd.y_end};
              end
              st <= S_DIV;
            end
            default: begin
              done_command <= q_cmd.command;
              out_valid <= 1'b1;
            end
          endcase
        end
        S_CLR: begin
          clr <= clr + AW'(1);
          if (&clr) begin
            if (!quiet) begin
              done_command <= cmdr;
              out_valid <= 1'b1;
            end
            st <= S_IDLE;
          end
        end
        S_RD: st <= S_RDW;
        S_RDW: begin
          pixel_value <= inb ? rdata : 8'd0;
          done_command <= cmdr; out_valid <= 1'b1; st <= S_IDLE;
        end
        S_DIV: begin
          xneg <= ex < cx;
          dx <= (ex < cx) ? 8'(cx - ex) : 8'(ex - cx);
          dy <= 8'(ey - cy);
          ymaj <= 8'(ey - cy) > ((ex < cx) ? 8'(cx - ex) : 8'(ex - cx));
          solid <= (ey == cy) || (ex == cx);
          acc <= '0;
          st <= S_RUN;
        end
        S_RUN: begin
          steps <= solid ? major : major - 8'd1;
          st <= S_STEP;
        end
        S_STEP: begin
          if (solid) begin
            if (steps == 8'd0) begin
              done_command <= cmdr; out_valid <= 1'b1; st <= S_IDLE;
            end else begin
              if (ymaj) cy <= cy + 9'd1;
              else cx <= xnext;
              steps <= steps - 8'd1;
            end
          end else if (!div_busy) begin
            if (steps == 8'd0) begin
              st <= S_END;
            end else begin
              acc <= accn;
              if (ymaj) begin
                cy <= cy + 9'd1;
                if (accn <= acc) cx <= xnext;
              end else begin
                cx <= xnext;
                if (accn <= acc) cy <= cy + 9'd1;
              end
              steps <= steps - 8'd1;
              st <= S_ARD;
            end
          end
        end
        S_ARD: st <= S_AWR;
        S_AWR: st <= S_BRD;
        S_BRD: st <= S_BWR;
        S_BWR: st <= S_STEP;
        S_END: begin
          done_command <= cmdr; out_valid <= 1'b1; st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- sv/wu_antialiased_line_drawer.sv -----
// Clear sweeps the whole store, one pixel per cycle.
// Draw: the divider runs first, then two read-modify-writes per interior major
// step; horizontal and vertical runs are written without the divider.
// Throughput: one command at a time; the next starts once the result beat leaves.
// Reset is synchronous; the store then fills white, and the input holds two beats.
// ---------------------------------------------------------------------------
// wu_antialiased_line_drawer
// Command queue in front of the drawing engine.
// ---------------------------------------------------------------------------
`default_nettype none
module wu_antialiased_line_drawer #(
  parameter int WIDTH  = wal_pkg::WIDTH_DEF,
  parameter int HEIGHT = wal_pkg::HEIGHT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] command,
  input  wire logic [7:0] x_start,
  input  wire logic [7:0] y_start,
  input  wire logic [7:0] x_end,
  input  wire logic [7:0] y_end,
  input  wire logic [7:0] gray,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      pixel_value,
  output logic [1:0]      done_command
);
  wal_pkg::cmd_t in_cmd, q_cmd;
  logic q_valid, q_take;
  assign in_cmd = '{command, x_start, y_start, x_end, y_end, gray};
  wal_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd)
  );
  wal_back #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd),
    .out_valid(out_valid), .out_stall(out_stall),
    .pixel_value(pixel_value), .done_command(done_command)
  );
endmodule
`default_nettype wire

// ----- sv/wal_checker.sv -----
// ---------------------------------------------------------------------------
// wal_checker
// Port-level checks of the line drawer.
// ---------------------------------------------------------------------------
`default_nettype none
`include "wu_antialiased_line_drawer_assert.svh"
module wal_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] pixel_value,
  input wire logic [1:0] done_command
);
  `WU_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(pixel_value))
  `WU_ASSERT_IMPL(a_zero, clk, rst, out_valid && done_command != wal_pkg::CMD_READ, pixel_value == 8'd0)
  `WU_ASSERT_NEXT(a_rst, clk, 1'b0, rst, !out_valid)
endmodule
bind wu_antialiased_line_drawer wal_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .pixel_value(pixel_value), .done_command(done_command)
);
`default_nettype wire

// ----- tb/sv/wu_antialiased_line_drawer_checker.sv -----
// ---------------------------------------------------------------------------
// Line drawer checker
// Watches the command and answer channels, keeps a shadow frame store,
// predicts each answer and compares it field by field.
// ---------------------------------------------------------------------------
`default_nettype none
module wu_antialiased_line_drawer_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic [1:0] command,
  input  wire logic [7:0] x_start,
  input  wire logic [7:0] y_start,
  input  wire logic [7:0] x_end,
  input  wire logic [7:0] y_end,
  input  wire logic [7:0] gray,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [7:0] pixel_value,
  input  wire logic [1:0] done_command,
  output int              fail_count,
  output int              pending_answers
);
  localparam int W = wal_pkg::WIDTH_DEF;
  localparam int H = wal_pkg::HEIGHT_DEF;

  typedef struct packed {
    logic [7:0] pixel;
    logic [1:0] cmd;
  } answer_t;

  logic [7:0] shadow_frame [W*H];
  answer_t    answer_q [$];

  function automatic logic [7:0] peek(int x, int y);
    if (x < 0 || y < 0 || x >= W || y >= H) return 8'd0;
    return shadow_frame[x + y * W];
  endfunction

  task automatic poke(int x, int y, logic [7:0] v);
    if (x < 0 || y < 0 || x >= W || y >= H) return;
    shadow_frame[x + y * W] = v;
  endtask

  task automatic mix(int x, int y, int w, int line);
    int bg;
    int v;
    if (x < 0 || y < 0 || x >= W || y >= H) return;
    bg = peek(x, y);
    v = (w & 255) * (bg - line) + line * 256;
    if (v < 0) v = 0;
    poke(x, y, 8'(v >> 8));
  endtask

  task automatic trace_line(int x0, int y0, int x1, int y1, int line);
    int dx, dy, xdir, t, n;
    logic [15:0] acc, step, prev;
    int w;
    xdir = 1;
    acc = '0;
    if (y0 > y1) begin
      t = y0; y0 = y1; y1 = t;
      t = x0; x0 = x1; x1 = t;
    end
    poke(x0, y0, 8'(line));
    dx = x1 - x0;
    if (dx < 0) begin
      xdir = -1;
      dx = -dx;
    end
    dy = y1 - y0;
    if (dy == 0) begin
      for (t = 0; t <= dx; t++) poke(x0 + t * xdir, y0, 8'(line));
      return;
    end
    if (dx == 0) begin
      for (t = 0; t <= dy; t++) poke(x0, y0 + t, 8'(line));
      return;
    end
    if (dy > dx) begin
      step = 16'((32'(dx) << 16) / 32'(dy));
      for (n = dy - 1; n > 0; n--) begin
        prev = acc;
        acc = acc + step;
        if (acc <= prev) x0 += xdir;
        y0++;
        w = acc >> 8;
        mix(x0, y0, w, line);
        mix(x0 + xdir, y0, w ^ 255, line);
      end
    end else begin
      step = 16'((32'(dy) << 16) / 32'(dx));
      for (n = dx - 1; n > 0; n--) begin
        prev = acc;
        acc = acc + step;
        if (acc <= prev) y0++;
        x0 += xdir;
        w = acc >> 8;
        mix(x0, y0, w, line);
        mix(x0, y0 + 1, w ^ 255, line);
      end
    end
    poke(x1, y1, 8'(line));
  endtask

  assign pending_answers = answer_q.size();

  always @(posedge clk) begin
    answer_t a;
    answer_t e;
    if (rst) begin
      fail_count <= 0;
      answer_q.delete();
      foreach (shadow_frame[i]) shadow_frame[i] = wal_pkg::WHITE;
    end else begin
      if (in_valid && !in_stall) begin
        a.pixel = 8'd0;
        a.cmd = command;
        case (command)
          wal_pkg::CMD_DRAW: trace_line(x_start, y_start, x_end, y_end, gray);
          wal_pkg::CMD_READ: a.pixel = peek(x_start, y_start);
          wal_pkg::CMD_CLEAR: foreach (shadow_frame[i]) shadow_frame[i] = gray;
          default: ;
        endcase
        answer_q.push_back(a);
      end
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected answer pixel_value=%0d done_command=%0d",
                   $time, pixel_value, done_command);
          fail_count <= fail_count + 1;
        end else begin
          e = answer_q.pop_front();
          if (e.pixel !== pixel_value || e.cmd !== done_command) begin
            $display("%0t: mismatch expected pixel_value=%0d done_command=%0d, got %0d %0d",
                     $time, e.pixel, e.cmd, pixel_value, done_command);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- tb/sv/tb_wu_antialiased_line_drawer.sv -----
// ---------------------------------------------------------------------------
// Line drawer testbench
// Sends directed and random draw, read, clear and no-op beats in bursts while the
// answer side stalls on its own pattern; the checker predicts every answer.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_wu_antialiased_line_drawer;
  localparam longint CYCLE_LIMIT = 64'd12_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] command = wal_pkg::CMD_NONE;
  logic [7:0] x_start = '0, y_start = '0, x_end = '0, y_end = '0, gray = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] pixel_value;
  logic [1:0] done_command;
  int fail_count;
  int pending_answers;
  longint cycles = 0;
  int stall_mode = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  wu_antialiased_line_drawer i_dut (
    .clk, .rst, .in_valid, .in_stall, .command, .x_start, .y_start, .x_end,
    .y_end, .gray, .out_valid, .out_stall, .pixel_value, .done_command
  );

  wu_antialiased_line_drawer_checker i_checker (
    .clk, .rst, .in_valid, .in_stall, .command, .x_start, .y_start, .x_end,
    .y_end, .gray, .out_valid, .out_stall, .pixel_value, .done_command,
    .fail_count, .pending_answers
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic send(logic [1:0] c, logic [7:0] xs, logic [7:0] ys,
                      logic [7:0] xe, logic [7:0] ye, logic [7:0] g);
    in_valid <= 1'b1;
    command <= c;
    x_start <= xs;
    y_start <= ys;
    x_end <= xe;
    y_end <= ye;
    gray <= g;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pause();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 12)) @(negedge clk);
  endtask

  task automatic random_beat();
    int k;
    logic [7:0] xs, ys, l;
    k = $urandom_range(0, 99);
    xs = 8'($urandom);
    ys = 8'($urandom);
    l = 8'($urandom_range(1, 24));
    if (k < 45)
      send(wal_pkg::CMD_DRAW, xs, ys, 8'(xs + $urandom_range(0, 24) - 12),
           8'(ys + $urandom_range(0, 24) - 12), 8'($urandom));
    else if (k < 50)
      send(wal_pkg::CMD_DRAW, xs, ys, 8'($urandom), 8'($urandom), 8'($urandom));
    else if (k < 55)
      send(wal_pkg::CMD_DRAW, xs, ys, xs + l,
           ys + (($urandom_range(0, 1) != 0) ? l : -l), 8'($urandom));
    else if (k < 92)
      send(wal_pkg::CMD_READ, xs, ys, 8'($urandom), 8'($urandom), 8'($urandom));
    else if (k < 94)
      send(wal_pkg::CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
           8'($urandom), 8'($urandom));
    else
      send(wal_pkg::CMD_NONE, 8'($urandom), 8'($urandom), 8'($urandom),
           8'($urandom), 8'($urandom));
  endtask

  initial begin
    int burst;
    int n;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send(wal_pkg::CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send(wal_pkg::CMD_READ, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send(wal_pkg::CMD_DRAW, 8'd10, 8'd20, 8'd40, 8'd20, 8'd0);
    send(wal_pkg::CMD_READ, 8'd25, 8'd20, 8'd0, 8'd0, 8'd0);
    send(wal_pkg::CMD_DRAW, 8'd50, 8'd60, 8'd50, 8'd30, 8'd7);
    send(wal_pkg::CMD_READ, 8'd50, 8'd45, 8'd0, 8'd0, 8'd0);
    send(wal_pkg::CMD_DRAW, 8'd5, 8'd5, 8'd5, 8'd5, 8'd100);
    send(wal_pkg::CMD_READ, 8'd5, 8'd5, 8'd0, 8'd0, 8'd0);
    send(wal_pkg::CMD_DRAW, 8'd100, 8'd100, 8'd120, 8'd120, 8'd30);
    send(wal_pkg::CMD_READ, 8'd110, 8'd110, 8'd0, 8'd0, 8'd0);
    send(wal_pkg::CMD_DRAW, 8'd200, 8'd10, 8'd180, 8'd30, 8'd60);
    send(wal_pkg::CMD_DRAW, 8'd0, 8'd0, 8'd255, 8'd9, 8'd0);
    send(wal_pkg::CMD_READ, 8'd128, 8'd5, 8'd0, 8'd0, 8'd0);
    send(wal_pkg::CMD_DRAW, 8'd254, 8'd255, 8'd250, 8'd0, 8'd255);
    send(wal_pkg::CMD_READ, 8'd255, 8'd128, 8'd0, 8'd0, 8'd0);
    send(wal_pkg::CMD_DRAW, 8'd3, 8'd250, 8'd0, 8'd255, 8'd90);
    send(wal_pkg::CMD_NONE, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send(wal_pkg::CMD_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send(wal_pkg::CMD_READ, 8'd77, 8'd88, 8'd0, 8'd0, 8'd0);
    send(wal_pkg::CMD_CLEAR, 8'd255, 8'd255, 8'd255, 8'd255, 8'd128);
    send(wal_pkg::CMD_DRAW, 8'd30, 8'd30, 8'd31, 8'd200, 8'd0);
    send(wal_pkg::CMD_READ, 8'd30, 8'd100, 8'd0, 8'd0, 8'd0);
    send(wal_pkg::CMD_READ, 8'd31, 8'd100, 8'd0, 8'd0, 8'd0);
    n = 0;
    while (n < 800) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        random_beat();
        n++;
      end
      if ($urandom_range(0, 2) != 0) pause();
    end
    in_valid <= 1'b0;
    while (pending_answers != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_answers == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
